// ===== rtl/sfmt_pkg.sv =====
// Shared types and constants of the SFMT random generator core.
// No dependencies; imported by every module of the block but the checker.
`default_nettype none

package sfmt_pkg;

  localparam int unsigned LANES             = 4;
  localparam int unsigned LANE_W            = 32;
  localparam int unsigned WORD_W            = LANES * LANE_W;
  localparam int unsigned RAND_W            = 31;
  localparam int unsigned RING_ENTRIES_DEF  = 156;
  localparam int unsigned MIDDLE_OFFSET_DEF = 122;

  localparam int unsigned SHL_BYTES_BITS = 8;
  localparam int unsigned SHR_WORD_BITS  = 11;
  localparam int unsigned SHL_WORD_BITS  = 18;

  localparam logic [LANE_W-1:0] LANE31_MASK = 32'h7fff_ffff;
  localparam logic [LANE_W-1:0] LANE_MASK [LANES] = '{
    32'hdfff_ffef, 32'hddfe_cb7f, 32'hbffa_ffff, 32'hbfff_fff6
  };

  // lane 0 sits in the top 32 bits
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_GEN  = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sfmt_ring_mem.sv =====
// State ring: 128-bit synchronous RAM, one write port, two read ports.
// Read data is registered; a same-edge write to a read address is bypassed.
`default_nettype none

module sfmt_ring_mem #(
  parameter int unsigned DEPTH = sfmt_pkg::RING_ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire sfmt_pkg::word_t       wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr_a,
  input  wire logic [AW-1:0]         raddr_m,
  output sfmt_pkg::word_t            rdata_a,
  output sfmt_pkg::word_t            rdata_m
);
  import sfmt_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: the item in flight may have just produced the entry we read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
      rdata_m <= (we && (waddr == raddr_m)) ? wdata : mem[raddr_m];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfmt_addr_gen.sv =====
// Ring position counter and middle-entry address for the SFMT core.
// Uses sfmt_pkg for defaults.
`default_nettype none

module sfmt_addr_gen #(
  parameter int unsigned RING_ENTRIES  = sfmt_pkg::RING_ENTRIES_DEF,
  parameter int unsigned MIDDLE_OFFSET = sfmt_pkg::MIDDLE_OFFSET_DEF,
  parameter int unsigned AW            = $clog2(RING_ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic          restart,
  output logic [AW-1:0]      addr_pos,
  output logic [AW-1:0]      addr_mid
);
  import sfmt_pkg::*;

  localparam int unsigned  OFF_M = MIDDLE_OFFSET % RING_ENTRIES;
  localparam logic [AW-1:0] LAST = AW'(RING_ENTRIES - 1);

  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;
  logic [AW:0]   mid_sum;

  always_comb begin
    pos_next = pos;
    if (restart) begin
      pos_next = '0;
    end else if (advance) begin
      pos_next = (pos == LAST) ? '0 : pos + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  always_comb begin
    mid_sum = {1'b0, pos} + (AW+1)'(OFF_M);
    if (mid_sum >= (AW+1)'(RING_ENTRIES)) begin
      addr_mid = AW'(mid_sum - (AW+1)'(RING_ENTRIES));
    end else begin
      addr_mid = AW'(mid_sum);
    end
  end

  assign addr_pos = pos;

endmodule

`default_nettype wire

// ===== rtl/sfmt_recur.sv =====
// SFMT recursion datapath: shifts, masks and XORs of one new 128-bit word.
// Uses sfmt_pkg for lane layout and shift constants.
`default_nettype none

module sfmt_recur (
  input  wire sfmt_pkg::word_t e_pos,
  input  wire sfmt_pkg::word_t e_mid,
  input  wire sfmt_pkg::word_t p_older,
  input  wire sfmt_pkg::word_t p_newer,
  output sfmt_pkg::word_t      new_word
);
  import sfmt_pkg::*;

  word_t wide_l;
  word_t wide_r;

  assign wide_l = e_pos << SHL_BYTES_BITS;
  assign wide_r = p_older >> SHL_BYTES_BITS;

  always_comb begin
    logic [LANE_W-1:0] b;
    logic [LANE_W-1:0] d;
    new_word = '0;
    for (int k = 0; k < LANES; k++) begin
      b = (e_mid[WORD_W-1-LANE_W*k -: LANE_W] >> SHR_WORD_BITS) & LANE_MASK[k];
      d = p_newer[WORD_W-1-LANE_W*k -: LANE_W] << SHL_WORD_BITS;
      new_word[WORD_W-1-LANE_W*k -: LANE_W] =
        (wide_l[WORD_W-1-LANE_W*k -: LANE_W] ^ e_pos[WORD_W-1-LANE_W*k -: LANE_W] ^ b ^
         wide_r[WORD_W-1-LANE_W*k -: LANE_W] ^ d) & LANE31_MASK;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfmt_random_generator_core.sv =====
// SFMT random generator core, top level.
// Depends on sfmt_pkg, sfmt_ring_mem, sfmt_addr_gen, sfmt_recur.
//
// Usage:
//   Input channel (in_valid / in_stall): cmd selects a beat type.
//     cmd = load: writes seed_lane0..3 into ring entry seed_index (ignored when
//     out of range) and sends the ring position back to entry 0. Loads into the
//     last two entries also seed the previous-word registers. No output beat.
//     cmd = generate: produces one 128-bit word, stores it back in the ring and
//     sends it as rand_lane0..3 (four Q0.31 fractions, lane 0 first).
//   Output channel (out_valid / out_stall): one beat per generate.
//   Throughput: one input beat per cycle while in_stall is low, loads and generates mixed freely.
//   A generate is registered into the compute stage together with its ring RAM read;
//   the recursion and write-back then load the result into the output register.
//   A generate waiting in the compute stage while the output register is held
//   stalls the input; one result waits in the output register meanwhile.
//   Reset: ring position and previous words go to zero, output empties.
//   The ring RAM is not cleared: generate only from entries already written.
`default_nettype none

module sfmt_random_generator_core #(
  parameter int unsigned RING_ENTRIES  = sfmt_pkg::RING_ENTRIES_DEF,
  parameter int unsigned MIDDLE_OFFSET = sfmt_pkg::MIDDLE_OFFSET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [7:0]  seed_index,
  input  wire logic [31:0] seed_lane0,
  input  wire logic [31:0] seed_lane1,
  input  wire logic [31:0] seed_lane2,
  input  wire logic [31:0] seed_lane3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      rand_lane0,
  output logic [30:0]      rand_lane1,
  output logic [30:0]      rand_lane2,
  output logic [30:0]      rand_lane3
);
  import sfmt_pkg::*;

  localparam int unsigned AW = $clog2(RING_ENTRIES);

  logic          in_acc;
  logic          acc_gen;
  logic          acc_load;
  logic [AW-1:0] addr_pos;
  logic [AW-1:0] addr_mid;
  word_t         rd_pos;
  word_t         rd_mid;
  word_t         new_word;

  // compute stage
  logic          s1_valid;
  cmd_t          s1_cmd;
  logic [AW-1:0] s1_addr;
  logic          s1_load_ok;
  logic          s1_is_pen;
  logic          s1_is_last;
  word_t         s1_seed;
  logic          s1_done;

  word_t         prev_older;
  word_t         prev_newer;

  logic          mem_we;
  word_t         mem_wdata;

  assign in_stall = s1_valid && (s1_cmd == CMD_GEN) && out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign acc_gen  = in_acc && (cmd == CMD_GEN);
  assign acc_load = in_acc && (cmd == CMD_LOAD);
  assign s1_done  = s1_valid && ((s1_cmd == CMD_LOAD) || !out_valid || !out_stall);

  sfmt_addr_gen #(
    .RING_ENTRIES  (RING_ENTRIES),
    .MIDDLE_OFFSET (MIDDLE_OFFSET),
    .AW            (AW)
  ) u_addr (
    .clk      (clk),
    .rst      (rst),
    .advance  (acc_gen),
    .restart  (acc_load),
    .addr_pos (addr_pos),
    .addr_mid (addr_mid)
  );

  assign mem_we    = s1_done && ((s1_cmd == CMD_GEN) || s1_load_ok);
  assign mem_wdata = (s1_cmd == CMD_GEN) ? new_word : s1_seed;

  sfmt_ring_mem #(
    .DEPTH (RING_ENTRIES),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (s1_addr),
    .wdata   (mem_wdata),
    .re      (in_acc),
    .raddr_a (addr_pos),
    .raddr_m (addr_mid),
    .rdata_a (rd_pos),
    .rdata_m (rd_mid)
  );

  sfmt_recur u_recur (
    .e_pos    (rd_pos),
    .e_mid    (rd_mid),
    .p_older  (prev_older),
    .p_newer  (prev_newer),
    .new_word (new_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd     <= cmd_t'(cmd);
      s1_addr    <= (cmd == CMD_GEN) ? addr_pos : AW'(seed_index);
      s1_load_ok <= 32'(seed_index) < 32'(RING_ENTRIES);
      s1_is_pen  <= 32'(seed_index) == 32'(RING_ENTRIES - 2);
      s1_is_last <= 32'(seed_index) == 32'(RING_ENTRIES - 1);
      s1_seed    <= {seed_lane0, seed_lane1, seed_lane2, seed_lane3};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_older <= '0;
      prev_newer <= '0;
    end else if (s1_done) begin
      if (s1_cmd == CMD_GEN) begin
        prev_older <= prev_newer;
        prev_newer <= new_word;
      end else begin
        if (s1_is_pen) begin
          prev_older <= s1_seed;
        end
        if (s1_is_last) begin
          prev_newer <= s1_seed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && (s1_cmd == CMD_GEN)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && (s1_cmd == CMD_GEN)) begin
      rand_lane0 <= new_word[WORD_W-2 -: RAND_W];
      rand_lane1 <= new_word[WORD_W-LANE_W-2 -: RAND_W];
      rand_lane2 <= new_word[WORD_W-2*LANE_W-2 -: RAND_W];
      rand_lane3 <= new_word[WORD_W-3*LANE_W-2 -: RAND_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfmt_checker.sv =====
// Port-level checks of the SFMT random generator core, bound to the top level.
// No package dependency.
`default_nettype none

module sfmt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [30:0] rand_lane0,
  input wire logic [30:0] rand_lane1,
  input wire logic [30:0] rand_lane2,
  input wire logic [30:0] rand_lane3
);

  // input only backs up behind a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held output beat");

  // after an accepted generate beat, the output must show a valid beat
  a_gen_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd) |-> ##2 out_valid)
    else $error("generate beat did not reach the output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(rand_lane0) && $stable(rand_lane1)
                                  && $stable(rand_lane2) && $stable(rand_lane3)))
    else $error("stalled output beat changed");

endmodule

bind sfmt_random_generator_core sfmt_checker u_sfmt_checker (.*);

`default_nettype wire
